>>> hw/rtl/mecanum_wheel_speed_limiter_macros.svh
// mecanum_wheel_speed_limiter_macros.svh
// assertion macros used by the checker file of the wheel speed limiter
// no dependencies
`ifndef MECANUM_WHEEL_SPEED_LIMITER_MACROS_SVH
`define MECANUM_WHEEL_SPEED_LIMITER_MACROS_SVH

// same-cycle implication, disabled while rst_n is low
`define MWSL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mwsl assertion failed");

// next-cycle implication, disabled while rst_n is low
`define MWSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mwsl assertion failed");

`endif

>>> hw/rtl/mwsl_pkg.sv
// mwsl_pkg.sv
// shared widths, register codes and item types of the wheel speed limiter
// no dependencies
`timescale 1ns / 1ps

package mwsl_pkg;

    localparam int WORD_W     = 32;
    localparam int WHEELS     = 4;
    localparam int GAIN_W     = 24;
    localparam int LIMIT_W    = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 31;
    localparam int IN_DATA_W  = 3 * WORD_W;
    localparam int OUT_DATA_W = WHEELS * WORD_W;
    localparam int OUT_USER_W = 2;
    // signed value times zero-extended gain
    localparam int PROD_W     = WORD_W + GAIN_W + 1;
    // quotient bits of the limit scaling and width of its dividend
    localparam int QUO_W      = LIMIT_W;
    localparam int NUM_W      = 2 * QUO_W;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_GAIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_DIST = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 2'd3;

    // configuration reset values
    localparam logic [GAIN_W-1:0]  RADIUS_GAIN_RST = 24'd65536;
    localparam logic [GAIN_W-1:0]  AXIS_GAIN_RST   = 24'd92682;
    localparam logic [GAIN_W-1:0]  CENTER_DIST_RST = 24'd65536;
    localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 31'd262144;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [WORD_W-1:0]        mag_t;
    typedef word_t [WHEELS-1:0]       wheel_vec_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  radius_gain;
        logic [GAIN_W-1:0]  axis_gain;
        logic [GAIN_W-1:0]  center_distance;
        logic [LIMIT_W-1:0] speed_limit;
    } cfg_t;

    typedef struct packed {
        word_t fwd_speed;
        word_t side_speed;
        word_t turn_rate;
        logic  open_mode;
    } cmd_t;

    // kinematics result handed to the limiter
    typedef struct packed {
        logic       open_mode;
        logic       sat;
        wheel_vec_t wheel;
    } kin_res_t;

    // one wheel entering the divider
    typedef struct packed {
        logic             use_div;
        logic             neg;
        logic [NUM_W-1:0] num;
        mag_t             den;
        word_t            keep;
    } lane_in_t;

    typedef lane_in_t [WHEELS-1:0] lane_vec_t;

    typedef struct packed {
        logic      sat;
        logic      scaled;
        lane_vec_t lane;
    } div_in_t;

    typedef struct packed {
        logic       sat;
        logic       scaled;
        wheel_vec_t wheel;
    } result_t;

endpackage

>>> hw/rtl/mwsl_kin.sv
// mwsl_kin.sv
// five-stage mecanum inverse kinematics: gain products, wheel sums, radius products
// depends on mwsl_pkg
`timescale 1ns / 1ps

module mwsl_kin
    import mwsl_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  cmd_t     cmd,
    input  cfg_t     cfg,
    output logic     out_valid,
    output kin_res_t out_res
);

    localparam int STAGES = 5;

    typedef logic signed [PROD_W-1:0] prod_t;

    typedef struct packed {
        logic  hit;
        word_t val;
    } sat_res_t;

    localparam prod_t ROUND_BIAS = (prod_t'(1) <<< FRAC_BITS) - prod_t'(1);
    localparam word_t WORD_MAX   = {1'b0, {(WORD_W-1){1'b1}}};
    localparam word_t WORD_MIN   = {1'b1, {(WORD_W-1){1'b0}}};
    // wheels whose x or y term enters negated
    localparam logic [WHEELS-1:0] NEG_X = 4'b0011;
    localparam logic [WHEELS-1:0] NEG_Y = 4'b1001;

    // divide by 2^FRAC_BITS, truncating toward zero
    function automatic prod_t trunc_frac(input prod_t p);
        prod_t biased;
        biased = p + (p[PROD_W-1] ? ROUND_BIAS : prod_t'(0));
        return biased >>> FRAC_BITS;
    endfunction

    // clip to the signed word range
    function automatic sat_res_t sat_word(input prod_t v);
        sat_res_t r;
        logic [PROD_W-WORD_W:0] hi_bits;
        hi_bits = v[PROD_W-1:WORD_W-1];
        r.hit = !((&hi_bits) || !(|hi_bits));
        if (!r.hit)
        begin
            r.val = v[WORD_W-1:0];
        end
        else if (v[PROD_W-1])
        begin
            r.val = WORD_MIN;
        end
        else
        begin
            r.val = WORD_MAX;
        end
        return r;
    endfunction

    logic [STAGES-1:0] vld_reg;

    prod_t px_reg, px_next;
    prod_t py_reg, py_next;
    prod_t pw_reg, pw_next;
    logic  open1_reg;

    word_t tx_reg, tx_next;
    word_t ty_reg, ty_next;
    word_t tw_reg, tw_next;
    logic  sat2_reg, sat2_next;
    logic  open2_reg;

    sat_res_t   tx_res, ty_res, tw_res;
    prod_t      sum3 [WHEELS];
    sat_res_t   sum_res [WHEELS];
    wheel_vec_t s_reg, s_next;
    logic       sat3_reg, sat3_next;
    logic       open3_reg;

    prod_t pr_reg [WHEELS];
    prod_t pr_next [WHEELS];
    logic  sat4_reg;
    logic  open4_reg;

    sat_res_t   w_res [WHEELS];
    wheel_vec_t w_reg, w_next;
    logic       sat5_reg, sat5_next;
    logic       open5_reg;

    // stage 1: axis and turn gain products
    always_comb
    begin
        px_next = prod_t'($signed(cmd.fwd_speed)) * prod_t'($signed({1'b0, cfg.axis_gain}));
        py_next = prod_t'($signed(cmd.side_speed)) * prod_t'($signed({1'b0, cfg.axis_gain}));
        pw_next = prod_t'($signed(cmd.turn_rate))
                  * prod_t'($signed({1'b0, cfg.center_distance}));
    end

    // stage 2: scale back and clip the three terms
    always_comb
    begin
        tx_res    = sat_word(trunc_frac(px_reg));
        ty_res    = sat_word(trunc_frac(py_reg));
        tw_res    = sat_word(trunc_frac(pw_reg));
        tx_next   = tx_res.val;
        ty_next   = ty_res.val;
        tw_next   = tw_res.val;
        sat2_next = tx_res.hit | ty_res.hit | tw_res.hit;
    end

    // stage 3: signed wheel sums, clipped
    always_comb
    begin
        sat3_next = sat2_reg;
        for (int i = 0; i < WHEELS; i++)
        begin
            sum3[i] = (NEG_X[i] ? -prod_t'(tx_reg) : prod_t'(tx_reg))
                      + (NEG_Y[i] ? -prod_t'(ty_reg) : prod_t'(ty_reg))
                      + prod_t'(tw_reg);
            sum_res[i] = sat_word(sum3[i]);
            s_next[i]  = sum_res[i].val;
            sat3_next  = sat3_next | sum_res[i].hit;
        end
    end

    // stage 4: radius products
    always_comb
    begin
        for (int i = 0; i < WHEELS; i++)
        begin
            pr_next[i] = prod_t'($signed(s_reg[i]))
                         * prod_t'($signed({1'b0, cfg.radius_gain}));
        end
    end

    // stage 5: scale back and clip the wheel speeds
    always_comb
    begin
        sat5_next = sat4_reg;
        for (int i = 0; i < WHEELS; i++)
        begin
            w_res[i]  = sat_word(trunc_frac(pr_reg[i]));
            w_next[i] = w_res[i].val;
            sat5_next = sat5_next | w_res[i].hit;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px_reg    <= px_next;
            py_reg    <= py_next;
            pw_reg    <= pw_next;
            open1_reg <= cmd.open_mode;
            tx_reg    <= tx_next;
            ty_reg    <= ty_next;
            tw_reg    <= tw_next;
            sat2_reg  <= sat2_next;
            open2_reg <= open1_reg;
            s_reg     <= s_next;
            sat3_reg  <= sat3_next;
            open3_reg <= open2_reg;
            pr_reg    <= pr_next;
            sat4_reg  <= sat3_reg;
            open4_reg <= open3_reg;
            w_reg     <= w_next;
            sat5_reg  <= sat5_next;
            open5_reg <= open4_reg;
        end
    end

    assign out_valid         = vld_reg[STAGES-1];
    assign out_res.open_mode = open5_reg;
    assign out_res.sat       = sat5_reg;
    assign out_res.wheel     = w_reg;

endmodule

>>> hw/rtl/mwsl_limit.sv
// mwsl_limit.sv
// four-stage limiter front: magnitudes, open-mode words, max search, scaling products
// depends on mwsl_pkg
`timescale 1ns / 1ps

module mwsl_limit
    import mwsl_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     adv,
    input  logic     in_valid,
    input  kin_res_t in_res,
    input  cfg_t     cfg,
    output logic     out_valid,
    output div_in_t  out_div
);

    localparam int STAGES = 4;
    localparam int MUL_W  = WORD_W + LIMIT_W;

    localparam word_t OPEN_HI     = 32767;
    localparam word_t OPEN_LO     = -32768;
    localparam mag_t  OPEN_HI_MAG = 32767;
    localparam mag_t  OPEN_LO_MAG = 32768;

    typedef mag_t [WHEELS-1:0] mag_vec_t;

    typedef struct packed {
        logic       open_mode;
        logic       sat;
        wheel_vec_t wheel;
        wheel_vec_t open_w;
        mag_vec_t   mag;
    } lim_item_t;

    logic [STAGES-1:0] vld_reg;

    lim_item_t st1_reg, st1_next;
    lim_item_t st2_reg;
    lim_item_t st3_reg;
    mag_t      whole [WHEELS];

    mag_t max01_reg, max01_next;
    mag_t max23_reg, max23_next;
    mag_t max_reg, max_next;
    logic scaled_reg, scaled_next;

    logic [MUL_W-1:0] prod [WHEELS];
    div_in_t          div_reg, div_next;

    // stage 1: magnitudes and open-mode whole numbers
    always_comb
    begin
        st1_next.open_mode = in_res.open_mode;
        st1_next.sat       = in_res.sat;
        st1_next.wheel     = in_res.wheel;
        for (int i = 0; i < WHEELS; i++)
        begin
            st1_next.mag[i] = in_res.wheel[i][WORD_W-1] ? mag_t'(-in_res.wheel[i])
                                                        : mag_t'(in_res.wheel[i]);
            whole[i] = st1_next.mag[i] >> FRAC_BITS;
            if (!in_res.wheel[i][WORD_W-1])
            begin
                st1_next.open_w[i] = (whole[i] > OPEN_HI_MAG) ? OPEN_HI : $signed(whole[i]);
            end
            else
            begin
                st1_next.open_w[i] = (whole[i] > OPEN_LO_MAG) ? OPEN_LO : -$signed(whole[i]);
            end
        end
    end

    // stage 2: pairwise maximum
    always_comb
    begin
        max01_next = (st1_reg.mag[1] > st1_reg.mag[0]) ? st1_reg.mag[1] : st1_reg.mag[0];
        max23_next = (st1_reg.mag[3] > st1_reg.mag[2]) ? st1_reg.mag[3] : st1_reg.mag[2];
    end

    // stage 3: overall maximum against the limit
    always_comb
    begin
        max_next    = (max23_reg > max01_reg) ? max23_reg : max01_reg;
        scaled_next = !st2_reg.open_mode && (max_next > mag_t'(cfg.speed_limit));
    end

    // stage 4: dividends for the scaling, pass-through words otherwise
    always_comb
    begin
        div_next.sat    = st3_reg.sat;
        div_next.scaled = scaled_reg;
        for (int i = 0; i < WHEELS; i++)
        begin
            prod[i] = MUL_W'(st3_reg.mag[i]) * MUL_W'(cfg.speed_limit);
            div_next.lane[i].use_div = scaled_reg;
            div_next.lane[i].neg     = st3_reg.wheel[i][WORD_W-1];
            div_next.lane[i].num     = prod[i][NUM_W-1:0];
            div_next.lane[i].den     = max_reg;
            div_next.lane[i].keep    = st3_reg.open_mode ? st3_reg.open_w[i]
                                                         : st3_reg.wheel[i];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_reg    <= st1_next;
            st2_reg    <= st1_reg;
            max01_reg  <= max01_next;
            max23_reg  <= max23_next;
            st3_reg    <= st2_reg;
            max_reg    <= max_next;
            scaled_reg <= scaled_next;
            div_reg    <= div_next;
        end
    end

    assign out_valid = vld_reg[STAGES-1];
    assign out_div   = div_reg;

endmodule

>>> hw/rtl/mwsl_div.sv
// mwsl_div.sv
// pipelined restoring divider, one quotient bit per stage, four wheel lanes
// depends on mwsl_pkg
`timescale 1ns / 1ps

module mwsl_div
    import mwsl_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    adv,
    input  logic    in_valid,
    input  div_in_t in_div,
    output logic    out_valid,
    output result_t out_res
);

    typedef struct packed {
        logic [WORD_W-1:0] rem;
        logic [QUO_W-1:0]  low;
        logic [QUO_W-1:0]  quo;
        mag_t              den;
        logic              use_div;
        logic              neg;
        word_t             keep;
    } lane_st_t;

    typedef lane_st_t [WHEELS-1:0] lane_st_vec_t;

    // load the dividend: its upper half is already below the divisor
    function automatic lane_st_t div_init(input lane_in_t l);
        lane_st_t r;
        r.rem     = {1'b0, l.num[NUM_W-1:QUO_W]};
        r.low     = l.num[QUO_W-1:0];
        r.quo     = '0;
        r.den     = l.den;
        r.use_div = l.use_div;
        r.neg     = l.neg;
        r.keep    = l.keep;
        return r;
    endfunction

    // one restoring step
    function automatic lane_st_t div_step(input lane_st_t s);
        lane_st_t        r;
        logic [WORD_W:0] trial;
        r     = s;
        trial = {s.rem, s.low[QUO_W-1]};
        r.low = {s.low[QUO_W-2:0], 1'b0};
        if (trial >= {1'b0, s.den})
        begin
            r.rem = WORD_W'(trial - {1'b0, s.den});
            r.quo = {s.quo[QUO_W-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[WORD_W-1:0];
            r.quo = {s.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    logic [QUO_W-1:0] vld_reg;
    logic [QUO_W-1:0] sat_reg;
    logic [QUO_W-1:0] scaled_reg;
    lane_st_vec_t     st_reg [QUO_W];
    lane_st_vec_t     st_next [QUO_W];
    lane_st_vec_t     fin;

    // one quotient bit per stage and lane
    always_comb
    begin
        for (int l = 0; l < WHEELS; l++)
        begin
            st_next[0][l] = div_step(div_init(in_div.lane[l]));
            for (int k = 1; k < QUO_W; k++)
            begin
                st_next[k][l] = div_step(st_reg[k-1][l]);
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[QUO_W-2:0], in_valid};
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sat_reg    <= {sat_reg[QUO_W-2:0], in_div.sat};
            scaled_reg <= {scaled_reg[QUO_W-2:0], in_div.scaled};
            for (int k = 0; k < QUO_W; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // restore the sign, or pass the unscaled word
    assign fin = st_reg[QUO_W-1];

    always_comb
    begin
        out_res.sat    = sat_reg[QUO_W-1];
        out_res.scaled = scaled_reg[QUO_W-1];
        for (int l = 0; l < WHEELS; l++)
        begin
            if (!fin[l].use_div)
            begin
                out_res.wheel[l] = fin[l].keep;
            end
            else if (fin[l].neg)
            begin
                out_res.wheel[l] = -$signed({1'b0, fin[l].quo});
            end
            else
            begin
                out_res.wheel[l] = $signed({1'b0, fin[l].quo});
            end
        end
    end

    assign out_valid = vld_reg[QUO_W-1];

endmodule

>>> hw/rtl/mecanum_wheel_speed_limiter.sv
// mecanum_wheel_speed_limiter.sv
// top level: stream ports, configuration registers, pipeline and output register
// depends on mwsl_pkg, mwsl_kin, mwsl_limit, mwsl_div
`timescale 1ns / 1ps

// Mecanum wheel speed limiter.
// A chassis command (fwd_speed, side_speed, turn_rate on s_axis_tdata, open_mode
// on s_axis_tuser) is turned into four wheel speeds on m_axis_tdata, with the
// scaled and saturated flags on m_axis_tuser. In closed mode the speeds are
// scaled by speed_limit / max when the largest magnitude exceeds the limit; in
// open mode they are whole numbers clipped to the int16 range.
// Configuration is written through cfg_we / cfg_idx / cfg_data, one register
// per cycle; the user must write it only while no transfer is in flight, since
// the block itself does not enforce this. The pipeline holds five kinematics
// stages, four limiter stages, a 31-stage divider (one quotient bit per stage)
// and the output register.
// Throughput: one transfer per cycle on both sides while m_axis_tready stays high.
// Reset clears all valid bits and loads the default register values.
// While the receiver stalls the output holds its result; the pipeline keeps
// moving until a result reaches its last stage, then s_axis_tready drops.
module mecanum_wheel_speed_limiter
    import mwsl_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // fwd_speed [31:0], side_speed [63:32], turn_rate [95:64]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // open_mode [0]
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // wheel_a [31:0], wheel_b [63:32], wheel_c [95:64], wheel_d [127:96]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // was_scaled [0], was_saturated [1]
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_idx,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg_reg;
    cmd_t     cmd;
    logic     adv;
    logic     out_load;
    logic     kin_valid;
    kin_res_t kin_res;
    logic     lim_valid;
    div_in_t  lim_div;
    logic     div_valid;
    result_t  div_res;
    logic     out_valid_reg;
    result_t  out_res_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.radius_gain     <= RADIUS_GAIN_RST;
            cfg_reg.axis_gain       <= AXIS_GAIN_RST;
            cfg_reg.center_distance <= CENTER_DIST_RST;
            cfg_reg.speed_limit     <= SPEED_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_RADIUS_GAIN: cfg_reg.radius_gain     <= cfg_data[GAIN_W-1:0];
                REG_AXIS_GAIN:   cfg_reg.axis_gain       <= cfg_data[GAIN_W-1:0];
                REG_CENTER_DIST: cfg_reg.center_distance <= cfg_data[GAIN_W-1:0];
                REG_SPEED_LIMIT: cfg_reg.speed_limit     <= cfg_data[LIMIT_W-1:0];
            endcase
        end
    end

    // input unpacking
    assign cmd.fwd_speed  = s_axis_tdata[WORD_W-1:0];
    assign cmd.side_speed = s_axis_tdata[2*WORD_W-1:WORD_W];
    assign cmd.turn_rate  = s_axis_tdata[3*WORD_W-1:2*WORD_W];
    assign cmd.open_mode  = s_axis_tuser[0];

    // pipeline moves unless a finished result is blocked behind a stalled output
    assign out_load      = !out_valid_reg || m_axis_tready;
    assign adv           = out_load || !div_valid;
    assign s_axis_tready = adv;

    mwsl_kin #(
        .FRAC_BITS (FRAC_BITS)
    ) u_kin (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_axis_tvalid),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .out_valid (kin_valid),
        .out_res   (kin_res)
    );

    mwsl_limit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_limit (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (kin_valid),
        .in_res    (kin_res),
        .cfg       (cfg_reg),
        .out_valid (lim_valid),
        .out_div   (lim_div)
    );

    mwsl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (lim_valid),
        .in_div    (lim_div),
        .out_valid (div_valid),
        .out_res   (div_res)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= div_valid;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg <= div_res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_res_reg.wheel;
    assign m_axis_tuser  = {out_res_reg.sat, out_res_reg.scaled};

endmodule

>>> hw/rtl/mwsl_checker.sv
// mwsl_checker.sv
// port-level checks of the wheel speed limiter, bound to the top level
// depends on mwsl_pkg and mecanum_wheel_speed_limiter_macros.svh
`timescale 1ns / 1ps
`include "mecanum_wheel_speed_limiter_macros.svh"

module mwsl_checker
    import mwsl_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    localparam logic [WORD_W-1:0] MOST_NEG = {1'b1, {(WORD_W-1){1'b0}}};

    logic              out_stall;
    logic              scaled_out;
    logic [WHEELS-1:0] wheel_min;

    // output held back by the receiver
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign scaled_out = m_axis_tvalid && m_axis_tuser[0];

    // wheels that show the most negative word
    always_comb
    begin
        for (int i = 0; i < WHEELS; i++)
        begin
            wheel_min[i] = (m_axis_tdata[i*WORD_W +: WORD_W] == MOST_NEG);
        end
    end

    // a stalled result stays valid
    `MWSL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid)

    // and keeps its data
    `MWSL_ASSERT_NEXT(a_data_hold, clk, rst_n, out_stall, $stable({m_axis_tuser, m_axis_tdata}))

    // input back-pressure only comes from a stalled output
    `MWSL_ASSERT_SAME(a_ready_cause, clk, rst_n, !s_axis_tready, out_stall)

    // reset empties the output
    `MWSL_ASSERT_NEXT(a_reset_empty, clk, 1'b1, !rst_n, !m_axis_tvalid)

    // a scaled speed never exceeds the limit, so never reaches the most negative word
    `MWSL_ASSERT_SAME(a_scaled_range, clk, rst_n, scaled_out, !(|wheel_min))

endmodule

bind mecanum_wheel_speed_limiter mwsl_checker u_mwsl_checker (.*);

>>> dv/mecanum_wheel_speed_limiter_tb.sv
// mecanum_wheel_speed_limiter_tb.sv
// self-checking bench for the wheel speed limiter: directed table, then random commands
// depends on mwsl_pkg and mecanum_wheel_speed_limiter
`timescale 1ns / 1ps

module mecanum_wheel_speed_limiter_tb;
    import mwsl_pkg::*;

    localparam int FRAC_BITS    = 16;
    localparam int PHASES       = 9;
    localparam int PHASE_CMDS   = 205;
    localparam int HOLD_CYCLES  = 250;
    localparam int HOLD_AFTER   = 300;
    localparam int DRAIN_CYCLES = 60;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    typedef longint unsigned u64_t;

    // one row of the directed table; want is only used when typed is set
    typedef struct {
        cmd_t    cmd;
        bit      typed;
        result_t want;
    } cmd_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // fwd_speed [31:0], side_speed [63:32], turn_rate [95:64]
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    // open_mode [0]
    logic [0:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // wheel_a [31:0], wheel_b [63:32], wheel_c [95:64], wheel_d [127:96]
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // was_scaled [0], was_saturated [1]
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    cfg_t     gains_now;
    result_t  pending_wheels[$];
    cmd_row_t directed_rows[$];
    int       mismatches;
    int       cmds_sent;

    mecanum_wheel_speed_limiter #(
        .FRAC_BITS(FRAC_BITS)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .cfg_we(cfg_we),
        .cfg_idx(cfg_idx),
        .cfg_data(cfg_data)
    );

    // 100 MHz clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // clip to the signed 32-bit range, flagging any clip
    function automatic longint clip_s32(longint v, inout bit clipped);
        if (v > S32_MAX)
        begin
            clipped = 1'b1;
            return S32_MAX;
        end
        if (v < S32_MIN)
        begin
            clipped = 1'b1;
            return S32_MIN;
        end
        return v;
    endfunction

    // exact product, shifted down truncating toward zero, then clipped
    function automatic longint apply_gain(longint a, longint g, inout bit clipped);
        longint p;
        longint q;
        p = a * g;
        if (p < 0)
            q = -((-p) >> FRAC_BITS);
        else
            q = p >> FRAC_BITS;
        return clip_s32(q, clipped);
    endfunction

    // wheel set points for one chassis command under the given gains
    function automatic result_t predict_wheels(cmd_t c, cfg_t k);
        bit      clipped;
        bit      limited;
        longint  tx;
        longint  ty;
        longint  tw;
        longint  s;
        longint  q;
        longint  w [WHEELS];
        u64_t    mag;
        u64_t    peak;
        u64_t    lim;
        result_t r;
        clipped = 1'b0;
        limited = 1'b0;
        peak    = 0;
        lim     = u64_t'(k.speed_limit);
        tx = apply_gain(longint'(c.fwd_speed), longint'(k.axis_gain), clipped);
        ty = apply_gain(longint'(c.side_speed), longint'(k.axis_gain), clipped);
        tw = apply_gain(longint'(c.turn_rate), longint'(k.center_distance), clipped);
        // wheel signs on (fwd, side): a (-,-), b (-,+), c (+,+), d (+,-)
        for (int i = 0; i < WHEELS; i++)
        begin
            s = ((i < 2) ? -tx : tx) + ((i == 1 || i == 2) ? ty : -ty) + tw;
            s = clip_s32(s, clipped);
            w[i] = apply_gain(s, longint'(k.radius_gain), clipped);
        end
        if (c.open_mode)
        begin
            // whole numbers, truncated toward zero and clipped to int16
            for (int i = 0; i < WHEELS; i++)
            begin
                mag = (w[i] < 0) ? u64_t'(-w[i]) : u64_t'(w[i]);
                q = longint'(mag >> FRAC_BITS);
                if (w[i] < 0)
                    q = -q;
                if (q > 32767)
                    q = 32767;
                if (q < -32768)
                    q = -32768;
                w[i] = q;
            end
        end
        else
        begin
            for (int i = 0; i < WHEELS; i++)
            begin
                mag = (w[i] < 0) ? u64_t'(-w[i]) : u64_t'(w[i]);
                if (mag > peak)
                    peak = mag;
            end
            // proportional scaling once the fastest wheel passes the limit
            if (peak > lim)
            begin
                limited = 1'b1;
                for (int i = 0; i < WHEELS; i++)
                begin
                    mag = (w[i] < 0) ? u64_t'(-w[i]) : u64_t'(w[i]);
                    mag = mag * lim / peak;
                    w[i] = (w[i] < 0) ? -longint'(mag) : longint'(mag);
                end
            end
        end
        for (int i = 0; i < WHEELS; i++)
            r.wheel[i] = word_t'(w[i]);
        r.scaled = limited;
        r.sat    = clipped;
        return r;
    endfunction

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // speed value: mostly a few units either way, some full range, some extremes
    function automatic word_t rand_speed();
        int v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: return 32'sh80000000;
                    1: return 32'sh7FFFFFFF;
                    2: return 32'sh00000000;
                    3: return -32'sd1;
                    default: return 32'sh00010000;
                endcase
            end
            1, 2, 3: return word_t'($urandom);
            default:
            begin
                v = $urandom_range(0, 12 * 65536);
                if ($urandom_range(0, 1))
                    v = -v;
                return word_t'(v);
            end
        endcase
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        c.fwd_speed  = rand_speed();
        c.side_speed = rand_speed();
        c.turn_rate  = rand_speed();
        c.open_mode  = ($urandom_range(0, 9) < 3);
        return c;
    endfunction

    task automatic add_row(word_t fwd, word_t side, word_t turn, logic open, bit typed,
                           word_t wheel_all, logic scaled);
        cmd_row_t row;
        row.cmd.fwd_speed   = fwd;
        row.cmd.side_speed  = side;
        row.cmd.turn_rate   = turn;
        row.cmd.open_mode   = open;
        row.typed           = typed;
        row.want.wheel      = {WHEELS{wheel_all}};
        row.want.scaled     = scaled;
        row.want.sat        = 1'b0;
        directed_rows.push_back(row);
    endtask

    // register write; the predictor copy follows at once since the block is idle
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            REG_RADIUS_GAIN: gains_now.radius_gain     = val[GAIN_W-1:0];
            REG_AXIS_GAIN:   gains_now.axis_gain       = val[GAIN_W-1:0];
            REG_CENTER_DIST: gains_now.center_distance = val[GAIN_W-1:0];
            REG_SPEED_LIMIT: gains_now.speed_limit     = val[LIMIT_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // one command transfer, then an optional gap with tvalid low
    task automatic send_cmd(cmd_t c, bit typed, result_t typed_want, int gap);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {c.turn_rate, c.side_speed, c.fwd_speed};
        s_axis_tuser  <= c.open_mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_wheels.push_back(typed ? typed_want : predict_wheels(c, gains_now));
        cmds_sent++;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every command has produced its result
    task automatic wait_drained();
        while (pending_wheels.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // register settings between phases
    task automatic apply_setting(int sel);
        case (sel)
            0:
            begin
                // all ones on the bus: gains masked to their width, widest limit
                write_reg(REG_RADIUS_GAIN, {CFG_DATA_W{1'b1}});
                write_reg(REG_AXIS_GAIN, {CFG_DATA_W{1'b1}});
                write_reg(REG_CENTER_DIST, {CFG_DATA_W{1'b1}});
                write_reg(REG_SPEED_LIMIT, {CFG_DATA_W{1'b1}});
            end
            1:
            begin
                write_reg(REG_RADIUS_GAIN, '0);
                write_reg(REG_AXIS_GAIN, '0);
                write_reg(REG_CENTER_DIST, '0);
                write_reg(REG_SPEED_LIMIT, CFG_DATA_W'(1));
            end
            2:
            begin
                // zero limit: in closed mode any motion scales every wheel to zero
                write_reg(REG_RADIUS_GAIN, CFG_DATA_W'(RADIUS_GAIN_RST));
                write_reg(REG_AXIS_GAIN, CFG_DATA_W'(AXIS_GAIN_RST));
                write_reg(REG_CENTER_DIST, CFG_DATA_W'(CENTER_DIST_RST));
                write_reg(REG_SPEED_LIMIT, '0);
            end
            3:
            begin
                write_reg(REG_RADIUS_GAIN, CFG_DATA_W'($urandom_range(32768, 131072)));
                write_reg(REG_AXIS_GAIN, CFG_DATA_W'($urandom_range(0, 131072)));
                write_reg(REG_CENTER_DIST, CFG_DATA_W'($urandom_range(0, 131072)));
                write_reg(REG_SPEED_LIMIT, CFG_DATA_W'($urandom_range(1, 16 * 65536)));
            end
            default:
            begin
                write_reg(REG_RADIUS_GAIN, CFG_DATA_W'($urandom));
                write_reg(REG_AXIS_GAIN, CFG_DATA_W'($urandom));
                write_reg(REG_CENTER_DIST, CFG_DATA_W'($urandom));
                write_reg(REG_SPEED_LIMIT, CFG_DATA_W'($urandom));
            end
        endcase
    endtask

    // command side: directed table, then random phases under changing settings
    initial
    begin : stimulus
        cmd_t    c;
        result_t none;
        int      gap;
        int      burst_left;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_we        = 1'b0;
        cfg_idx       = '0;
        cfg_data      = '0;
        mismatches    = 0;
        cmds_sent     = 0;
        burst_left    = 0;
        none          = '0;
        gains_now.radius_gain     = RADIUS_GAIN_RST;
        gains_now.axis_gain       = AXIS_GAIN_RST;
        gains_now.center_distance = CENTER_DIST_RST;
        gains_now.speed_limit     = SPEED_LIMIT_RST;

        // directed rows under the reset gains: fwd, side, turn, open, typed, wheels, scaled
        add_row(32'sd0, 32'sd0, 32'sd0, 1'b0, 1'b1, 32'sd0, 1'b0);
        add_row(32'sd0, 32'sd0, 32'sd0, 1'b1, 1'b1, 32'sd0, 1'b0);
        // turn 4.0 lands exactly on the limit and is left alone
        add_row(32'sd0, 32'sd0, 32'sd262144, 1'b0, 1'b1, 32'sd262144, 1'b0);
        // turn 5.0 is pulled back to the limit
        add_row(32'sd0, 32'sd0, 32'sd327680, 1'b0, 1'b1, 32'sd262144, 1'b1);
        add_row(32'sd0, 32'sd0, 32'sd65536, 1'b1, 1'b1, 32'sd1, 1'b0);
        // open mode truncates -1.5 toward zero
        add_row(32'sd0, 32'sd0, -32'sd98304, 1'b1, 1'b1, -32'sd1, 1'b0);
        add_row(32'sd0, 32'sd0, 32'sd65536, 1'b0, 1'b1, 32'sd65536, 1'b0);
        // extremes of each field, both modes
        add_row(32'sh7FFFFFFF, 32'sd0, 32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0);
        add_row(32'sh80000000, 32'sd0, 32'sd0, 1'b0, 1'b0, 32'sd0, 1'b0);
        add_row(32'sd0, 32'sh7FFFFFFF, 32'sd0, 1'b1, 1'b0, 32'sd0, 1'b0);
        add_row(32'sd0, 32'sh80000000, 32'sd0, 1'b1, 1'b0, 32'sd0, 1'b0);
        add_row(32'sd0, 32'sd0, 32'sh7FFFFFFF, 1'b0, 1'b0, 32'sd0, 1'b0);
        add_row(32'sd0, 32'sd0, 32'sh80000000, 1'b0, 1'b0, 32'sd0, 1'b0);
        add_row(32'sd0, 32'sd0, 32'sh7FFFFFFF, 1'b1, 1'b0, 32'sd0, 1'b0);
        add_row(32'sd0, 32'sd0, 32'sh80000000, 1'b1, 1'b0, 32'sd0, 1'b0);
        add_row(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 1'b0, 1'b0, 32'sd0, 1'b0);
        add_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b0, 1'b0, 32'sd0, 1'b0);
        add_row(32'sh80000000, 32'sh80000000, 32'sh80000000, 1'b1, 1'b0, 32'sd0, 1'b0);
        add_row(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 1'b1, 1'b0, 32'sd0, 1'b0);
        add_row(-32'sd1, 32'sd1, -32'sd1, 1'b0, 1'b0, 32'sd0, 1'b0);
        add_row(32'sd65536, 32'sd65536, 32'sd65536, 1'b0, 1'b0, 32'sd0, 1'b0);
        add_row(32'sd65536, -32'sd65536, 32'sd0, 1'b1, 1'b0, 32'sd0, 1'b0);
        add_row(32'sd131072, 32'sd0, -32'sd65536, 1'b0, 1'b0, 32'sd0, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_cmd(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want,
                     pick_gap());

        // random phases, each behind a fresh register setting
        for (int p = 0; p < PHASES; p++)
        begin
            s_axis_tvalid <= 1'b0;
            wait_drained();
            apply_setting((p < 5) ? p : $urandom_range(3, 4));
            for (int n = 0; n < PHASE_CMDS; n++)
            begin
                c = rand_cmd();
                if (burst_left > 0)
                begin
                    burst_left--;
                    gap = 0;
                end
                else
                begin
                    if ($urandom_range(0, 49) == 0)
                        burst_left = 40;
                    gap = pick_gap();
                end
                send_cmd(c, 1'b0, none, gap);
            end
        end

        // drain and watch a little longer for strays
        s_axis_tvalid <= 1'b0;
        while (pending_wheels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // result side: random stalls, one long hold-off once traffic is flowing
    initial
    begin : result_ready
        int  run;
        int  pause;
        bit  held;
        held          = 1'b0;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && cmds_sent >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            run = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 120) : $urandom_range(1, 8);
            repeat (run) @(posedge clk);
            pause = pick_gap();
            if (pause > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(posedge clk);
            end
        end
    end

    // compare each result transfer with the oldest pending command
    always @(posedge clk)
    begin : result_check
        result_t    want;
        wheel_vec_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_wheels.size() == 0)
            begin
                $error("result with no command pending: tdata %h tuser %b",
                       m_axis_tdata, m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = pending_wheels.pop_front();
                for (int i = 0; i < WHEELS; i++)
                begin
                    if (got[i] !== want.wheel[i])
                    begin
                        $error("wheel_%c expected %0d actual %0d", 8'(97 + i),
                               want.wheel[i], got[i]);
                        mismatches++;
                    end
                end
                if (m_axis_tuser[0] !== want.scaled)
                begin
                    $error("was_scaled expected %0b actual %0b", want.scaled, m_axis_tuser[0]);
                    mismatches++;
                end
                if (m_axis_tuser[1] !== want.sat)
                begin
                    $error("was_saturated expected %0b actual %0b", want.sat, m_axis_tuser[1]);
                    mismatches++;
                end
            end
        end
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/mwsl_pkg.sv
hw/rtl/mwsl_kin.sv
hw/rtl/mwsl_limit.sv
hw/rtl/mwsl_div.sv
hw/rtl/mecanum_wheel_speed_limiter.sv
hw/rtl/mwsl_checker.sv
dv/mecanum_wheel_speed_limiter_tb.sv
